[src/sth_pkg.sv]
package sth_pkg;

   // word format of the angle and the sine
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = DATA_WIDTH - 3;
   // internal fixed point: Q8.55
   localparam int INT_FRAC    = 55;
   localparam int ALIGN_SHIFT = INT_FRAC - FRAC_BITS;
   localparam int ACC_WIDTH   = 64;
   // magnitude of x squared stays below 2^60
   localparam int X2_WIDTH    = 60;
   localparam int XMAG_WIDTH  = DATA_WIDTH;

   // one cell per Horner step
   localparam int NUM_CELLS  = 16;
   localparam int CELL_IDX_W = $clog2(NUM_CELLS);
   localparam int TERMS_W    = $clog2(NUM_CELLS + 1);

   // configuration port
   localparam int CFG_WIDTH      = 5;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic REG_MAX_POWER = 1'b0;
   localparam logic [CFG_WIDTH-1:0] MAX_POWER_RESET = 5'd11;

   localparam logic [ACC_WIDTH-1:0] MAG_SAT = {1'b0, {(ACC_WIDTH-1){1'b1}}};

   // 1/p! in Q2.61 for p = 1, 3, ..., 31
   localparam logic [63:0] COEF_MAG [NUM_CELLS] = '{
      64'd2305843009213693952, 64'd384307168202282325, 64'd19215358410114116,
      64'd457508533574146, 64'd6354285188530, 64'd57766228987, 64'd370296340,
      64'd1763316, 64'd6483, 64'd19, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0
   };

   // pipeline sideband that travels with every word
   typedef struct packed {
      logic                  valid;
      logic                  xneg;
      logic [XMAG_WIDTH-1:0] xmag;
      logic [X2_WIDTH-1:0]   x2mag;
   } side_type;

   // signed coefficient of power 2k+1, rounded to Q8.55
   function automatic logic signed [ACC_WIDTH-1:0] coef_q(input logic [CELL_IDX_W-1:0] k);
      logic [63:0] m;
      m = (COEF_MAG[k] + 64'd32) >> 6;
      coef_q = k[0] ? -$signed(m) : $signed(m);
   endfunction

endpackage

[src/sth_mulq.sv]
module sth_mulq
   import sth_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic [ACC_WIDTH-1:0] a_mag,
   input  logic [ACC_WIDTH-1:0] b_mag,
   input  logic                 src_neg,
   input  side_type             src_side,
   output logic [ACC_WIDTH-1:0] prod_mag,
   output logic                 prod_neg,
   output side_type             prod_side
);

   logic [63:0]          p00_ff, p01_ff, p10_ff, p11_ff;
   logic                 neg_ff;
   side_type             side_ff;
   logic [127:0]         sum;
   logic                 sat;
   logic [ACC_WIDTH-1:0] mag_in;
   logic [ACC_WIDTH-1:0] mag_ff;
   logic                 neg2_ff;
   side_type             side2_ff;

   // stage 1: four 32x32 partial products
   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff <= 64'(a_mag[31:0])  * 64'(b_mag[31:0]);
         p01_ff <= 64'(a_mag[31:0])  * 64'(b_mag[63:32]);
         p10_ff <= 64'(a_mag[63:32]) * 64'(b_mag[31:0]);
         p11_ff <= 64'(a_mag[63:32]) * 64'(b_mag[63:32]);
         neg_ff <= src_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= '0;
         side2_ff <= '0;
      end else if (en) begin
         side_ff  <= src_side;
         side2_ff <= side_ff;
      end
   end

   // stage 2: combine, round half up on the magnitude, drop 55 fraction bits, saturate
   always_comb begin
      sum = {p11_ff, 64'd0}
          + ({64'd0, p01_ff} << 32)
          + ({64'd0, p10_ff} << 32)
          + {64'd0, p00_ff}
          + (128'd1 << (INT_FRAC - 1));
      sat    = (|sum[127:INT_FRAC+ACC_WIDTH]) | sum[INT_FRAC+ACC_WIDTH-1];
      mag_in = sat ? MAG_SAT : sum[INT_FRAC+ACC_WIDTH-1:INT_FRAC];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= mag_in;
         neg2_ff <= neg_ff;
      end
   end

   assign prod_mag  = mag_ff;
   assign prod_neg  = neg2_ff;
   assign prod_side = side2_ff;

endmodule

[src/sth_front.sv]
module sth_front
   import sth_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         word_valid,
   input  logic signed [DATA_WIDTH-1:0] angle,
   output side_type                     dn_side
);

   logic                  xneg;
   logic [XMAG_WIDTH-1:0] xmag;
   logic [63:0]           sq;
   side_type              side_in;
   side_type              side_ff;

   // magnitude and square; x^2 in Q8.55 is (xmag^2 + 4) >> 3
   always_comb begin
      xneg          = angle[DATA_WIDTH-1];
      xmag          = xneg ? XMAG_WIDTH'(-angle) : XMAG_WIDTH'(angle);
      sq            = 64'(xmag) * 64'(xmag);
      side_in.valid = word_valid;
      side_in.xneg  = xneg;
      side_in.xmag  = xmag;
      side_in.x2mag = X2_WIDTH'((sq + 64'd4) >> 3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else if (en) begin
         side_ff <= side_in;
      end
   end

   assign dn_side = side_ff;

endmodule

[src/sth_cell.sv]
module sth_cell
   import sth_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic [CELL_IDX_W-1:0]       cell_k,
   input  logic [TERMS_W-1:0]          terms,
   input  side_type                    up_side,
   input  logic signed [ACC_WIDTH-1:0] up_acc,
   output side_type                    dn_side,
   output logic signed [ACC_WIDTH-1:0] dn_acc
);

   logic [ACC_WIDTH-1:0]        acc_mag;
   logic [ACC_WIDTH-1:0]        prod_mag;
   logic                        prod_neg;
   side_type                    prod_side;
   logic signed [ACC_WIDTH-1:0] prod;
   logic                        active;
   logic signed [ACC_WIDTH-1:0] acc_in;
   logic signed [ACC_WIDTH-1:0] acc_ff;
   side_type                    side_ff;

   assign acc_mag = up_acc[ACC_WIDTH-1] ? ACC_WIDTH'(-up_acc) : ACC_WIDTH'(up_acc);

   // acc * x^2
   sth_mulq u_mulq (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .a_mag     (acc_mag),
      .b_mag     (ACC_WIDTH'(up_side.x2mag)),
      .src_neg   (up_acc[ACC_WIDTH-1]),
      .src_side  (up_side),
      .prod_mag  (prod_mag),
      .prod_neg  (prod_neg),
      .prod_side (prod_side)
   );

   // add the coefficient; cells above the top power only pass the zero through
   always_comb begin
      active = TERMS_W'(cell_k) < terms;
      prod   = prod_neg ? -$signed(prod_mag) : $signed(prod_mag);
      acc_in = prod + (active ? coef_q(cell_k) : '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else if (en) begin
         side_ff <= prod_side;
      end
   end

   assign dn_side = side_ff;
   assign dn_acc  = acc_ff;

endmodule

[src/sth_tail.sv]
module sth_tail
   import sth_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  side_type                     up_side,
   input  logic signed [ACC_WIDTH-1:0]  up_acc,
   output logic                         res_valid,
   output logic signed [DATA_WIDTH-1:0] res_sine
);

   localparam int OMAG_WIDTH = ACC_WIDTH - ALIGN_SHIFT + 1;

   logic [ACC_WIDTH-1:0]  acc_mag;
   logic [ACC_WIDTH-1:0]  prod_mag;
   logic                  prod_neg;
   side_type              prod_side;
   logic                  rneg;
   logic [OMAG_WIDTH-1:0] omag;
   logic [OMAG_WIDTH-1:0] limit;
   logic [DATA_WIDTH-1:0] clip;

   assign acc_mag = up_acc[ACC_WIDTH-1] ? ACC_WIDTH'(-up_acc) : ACC_WIDTH'(up_acc);

   // acc * x, x widened to Q8.55
   sth_mulq u_mulq (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .a_mag     (acc_mag),
      .b_mag     (ACC_WIDTH'(up_side.xmag) << ALIGN_SHIFT),
      .src_neg   (up_acc[ACC_WIDTH-1] ^ up_side.xneg),
      .src_side  (up_side),
      .prod_mag  (prod_mag),
      .prod_neg  (prod_neg),
      .prod_side (prod_side)
   );

   // narrow to Q3.29 with rounding, then saturate
   always_comb begin
      rneg  = prod_neg & (|prod_mag);
      omag  = OMAG_WIDTH'((prod_mag + (ACC_WIDTH'(1) << (ALIGN_SHIFT - 1))) >> ALIGN_SHIFT);
      limit = (OMAG_WIDTH'(1) << (DATA_WIDTH - 1)) - (rneg ? OMAG_WIDTH'(0) : OMAG_WIDTH'(1));
      clip  = (omag > limit) ? limit[DATA_WIDTH-1:0] : omag[DATA_WIDTH-1:0];
      res_sine  = rneg ? -$signed(clip) : $signed(clip);
      res_valid = prod_side.valid;
   end

endmodule

[src/sine_taylor_horner.sv]
// sine_taylor_horner: sine of a Q3.29 angle from its Taylor polynomial, Horner form in x^2.
// req channel: one angle word per handshake, req_tdata signed Q3.29.
// rsp channel: one sine word per angle, rsp_tdata signed Q3.29, saturated, in input order.
// csr port: register max_power at byte address 0 (5 bits, highest odd power used,
//   even values round down, reset 11); write only while no words are in flight.
// Structure: an input stage that forms x^2, a row of 16 Horner cells (one per odd power,
//   highest first, each acc = acc * x^2 + c), a tail that multiplies by x and narrows.
//   Every cell holds a 3-register pipelined 64x64 multiply-round-saturate and adder.
// Path from req accept to rsp_tvalid: the front register, the registers of the 16 cells,
//   the two tail registers and the output register.
// Throughput: one angle per cycle while rsp_tready stays high.
// Stall: a skid register behind the output register takes one more word when rsp_tready
//   is low; after that req_tready drops and the whole pipeline holds.
// Reset: synchronous; empties the pipeline and the output side, max_power returns to 11.
module sine_taylor_horner
   import sth_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   // angle
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic signed [DATA_WIDTH-1:0]     req_tdata,   // [31:0] angle
   // sine
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic signed [DATA_WIDTH-1:0]     rsp_tdata,   // [31:0] sine
   // configuration
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]        csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]        csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]        csr_prdata,
   output logic                             csr_pready
);

   logic [CFG_WIDTH-1:0]        max_power_ff;
   logic [CFG_WIDTH-1:0]        max_power_in;
   logic                        csr_wr;
   logic [TERMS_W-1:0]          terms;
   logic                        adv;

   side_type                    chain_side [NUM_CELLS+1];
   logic signed [ACC_WIDTH-1:0] chain_acc  [NUM_CELLS+1];

   logic                         res_valid;
   logic signed [DATA_WIDTH-1:0] res_sine;

   logic                         out_valid_ff, out_valid_in;
   logic signed [DATA_WIDTH-1:0] out_data_ff, out_data_in;
   logic                         skid_valid_ff, skid_valid_in;
   logic signed [DATA_WIDTH-1:0] skid_data_ff, skid_data_in;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready
                     & (csr_paddr[2] == REG_MAX_POWER);
   assign max_power_in = csr_wr ? csr_pwdata[CFG_WIDTH-1:0] : max_power_ff;
   assign csr_prdata   = (csr_paddr[2] == REG_MAX_POWER) ?
                         CSR_DATA_WIDTH'(max_power_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_power_ff <= MAX_POWER_RESET;
      end else begin
         max_power_ff <= max_power_in;
      end
   end

   // number of Horner terms, 0 to 16
   assign terms = TERMS_W'(({1'b0, max_power_ff} + 6'd1) >> 1);

   // the pipeline moves whenever the skid register is free
   assign adv        = ~skid_valid_ff;
   assign req_tready = adv;

   sth_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .word_valid (req_tvalid),
      .angle      (req_tdata),
      .dn_side    (chain_side[0])
   );

   assign chain_acc[0] = '0;

   // row of Horner cells, highest power first
   for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
      sth_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (adv),
         .cell_k  (CELL_IDX_W'(NUM_CELLS - 1 - j)),
         .terms   (terms),
         .up_side (chain_side[j]),
         .up_acc  (chain_acc[j]),
         .dn_side (chain_side[j+1]),
         .dn_acc  (chain_acc[j+1])
      );
   end

   sth_tail u_tail (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .up_side   (chain_side[NUM_CELLS]),
      .up_acc    (chain_acc[NUM_CELLS]),
      .res_valid (res_valid),
      .res_sine  (res_sine)
   );

   // output register with skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_data_in  = res_sine;
         end
      end else if (res_valid && adv) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res_sine;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
